FILE: rtl/core/lcd_framebuffer_serial_refresh_macros.svh
// Assertion helpers for the frame buffer top module.
`ifndef LCD_FRAMEBUFFER_SERIAL_REFRESH_MACROS_SVH
`define LCD_FRAMEBUFFER_SERIAL_REFRESH_MACROS_SVH

// Checks a property on every rising edge of clk_i while out of reset.
`define LCDFB_ASSERT_PROP(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: assertion failed");

// Checks that a condition always implies another one in the same cycle.
`define LCDFB_ASSERT_IMP(label, ante, cons) \
  `LCDFB_ASSERT_PROP(label, (ante) |-> (cons))

`endif

FILE: rtl/core/lcdfb_pkg.sv
`default_nettype none

package lcdfb_pkg;

  localparam int unsigned STORE_BYTES_DEF = 2048;

  // Width of the byte index before it is checked against the store size.
  localparam int unsigned IDX_W = 12;

  localparam logic [IDX_W-1:0] WIDE_HALF_OFF   = 12'd1024;
  localparam logic [IDX_W-1:0] NARROW_HALF_OFF = 12'd16;

  localparam logic [7:0] SYNC_CMD     = 8'b11111000;
  localparam logic [7:0] SYNC_DATA    = 8'b11111010;
  localparam logic [7:0] CMD_EXT_BASE = 8'b00100100;
  localparam logic [7:0] CMD_EXT_GFX  = 8'b00100110;
  localparam logic [7:0] CMD_ADDR     = 8'h80;
  localparam logic [7:0] CMD_DISP_ON  = 8'b00001100;

  localparam logic [4:0] LAST_BYTE_WIDE   = 5'd23;
  localparam logic [4:0] LAST_BYTE_NARROW = 5'd31;
  localparam logic [4:0] LAST_LINE        = 5'd31;

  // Command word slots of a row refresh.
  localparam logic [1:0] SLOT_EXT_BASE = 2'd0;
  localparam logic [1:0] SLOT_EXT_GFX  = 2'd1;
  localparam logic [1:0] SLOT_ROW      = 2'd2;
  localparam logic [1:0] SLOT_COL      = 2'd3;

  typedef enum logic [2:0] {
    OP_SET_PIXEL = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_INVERT    = 3'd2,
    OP_INIT      = 3'd3,
    OP_REFRESH   = 3'd4
  } op_e;

  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_PX_RD,
    ST_PX_WR,
    ST_CLR,
    ST_INV_RD,
    ST_INV_WR,
    ST_ON,
    ST_CMD,
    ST_DRD,
    ST_DOUT
  } state_e;

  typedef struct packed {
    logic        is_data;
    logic [7:0]  word_value;
    logic [23:0] serial_frame;
    logic        controller;
    logic        end_of_controller;
    logic        last;
  } word_t;

  function automatic word_t make_word(logic is_data, logic [7:0] val, logic ctrl,
                                      logic eoc, logic last);
    word_t w;
    w.is_data           = is_data;
    w.word_value        = val;
    w.serial_frame      = {(is_data ? SYNC_DATA : SYNC_CMD), val[7:4], 4'h0,
                           val[3:0], 4'h0};
    w.controller        = ctrl;
    w.end_of_controller = eoc;
    w.last              = last;
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/lcdfb_if.sv
`default_nettype none

interface lcdfb_cfg_if;
  logic valid;
  logic ready;
  logic wide_panel;

  modport source (output valid, output wide_panel, input ready);
  modport sink (input valid, input wide_panel, output ready);
endinterface

interface lcdfb_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] pixel_x;
  logic [6:0] pixel_y;
  logic       pixel_on;

  modport source (output valid, output operation, output pixel_x, output pixel_y,
                  output pixel_on, input ready);
  modport sink (input valid, input operation, input pixel_x, input pixel_y,
                input pixel_on, output ready);
endinterface

interface lcdfb_word_if;
  logic        valid;
  logic        ready;
  logic        is_data;
  logic [7:0]  word_value;
  logic [23:0] serial_frame;
  logic        controller;
  logic        end_of_controller;
  logic        last;

  modport source (output valid, output is_data, output word_value, output serial_frame,
                  output controller, output end_of_controller, output last,
                  input ready);
  modport sink (input valid, input is_data, input word_value, input serial_frame,
                input controller, input end_of_controller, input last,
                output ready);
endinterface

`default_nettype wire

FILE: rtl/core/lcdfb_store.sv
`default_nettype none

module lcdfb_store #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = 11
) (
  input  wire logic             clk_i,
  input  wire logic             re_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [7:0]       wdata_i,
  output logic      [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/lcdfb_ctrl.sv
`default_nettype none

module lcdfb_ctrl
  import lcdfb_pkg::*;
#(
  parameter int unsigned StoreBytes = STORE_BYTES_DEF,
  parameter int unsigned AddrW      = $clog2(StoreBytes)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              wide_i,
  lcdfb_cmd_if.sink              cmd_i,
  lcdfb_word_if.source           word_o,
  output logic                   mem_re_o,
  output logic                   mem_we_o,
  output logic [AddrW-1:0]       mem_addr_o,
  output logic [7:0]             mem_wdata_o,
  input  wire logic [7:0]        mem_rdata_i
);

  localparam int unsigned CntW       = AddrW + 1;
  localparam int unsigned LenNarrow  = (StoreBytes < 1024) ? StoreBytes : 1024;
  localparam int unsigned LenWide    = (StoreBytes < 2048) ? StoreBytes : 2048;
  localparam logic [CntW-1:0] LastNarrow = CntW'(LenNarrow - 1);
  localparam logic [CntW-1:0] LastWide   = CntW'(LenWide - 1);
  localparam logic [CntW-1:0] LastStore  = CntW'(StoreBytes - 1);
  localparam logic [IDX_W-1:0] StoreLim  = IDX_W'(StoreBytes);

  state_e            state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [5:0]        rr_q, rr_d;
  logic [AddrW-1:0]  pix_addr_q, pix_addr_d;
  logic [7:0]        pix_mask_q, pix_mask_d;
  logic              pix_on_q, pix_on_d;
  logic              out_valid_q, out_valid_d;
  word_t             word_q, word_d;

  op_e               op;
  logic              accept;
  logic              out_free;
  logic [IDX_W-1:0]  pix_idx;
  logic              pix_ok;
  logic [5:0]        row;
  logic              ctrl;
  logic [4:0]        line;
  logic [IDX_W-1:0]  dat_idx;
  logic              byte_last;
  logic [CntW-1:0]   clr_last;
  logic [7:0]        cmd_val;
  logic [7:0]        dat_byte;
  logic              emit;
  word_t             emit_word;

  assign op       = op_e'(cmd_i.operation);
  assign accept   = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_valid_q || word_o.ready;

  // Two bytes per 16-pixel tile; the lower half sits 16 bytes (narrow) or
  // 1024 bytes (wide) further on.
  assign pix_idx = IDX_W'({cmd_i.pixel_y[4:0], cmd_i.pixel_x[7:4], cmd_i.pixel_x[3]})
                 + (cmd_i.pixel_y[5] ? (wide_i ? WIDE_HALF_OFF : NARROW_HALF_OFF)
                                     : '0);
  assign pix_ok  = !cmd_i.pixel_y[6]
                && (wide_i ? !(cmd_i.pixel_x[7] && cmd_i.pixel_x[6]) : !cmd_i.pixel_x[7])
                && (pix_idx < StoreLim);

  assign row       = wide_i ? rr_q : {1'b0, rr_q[4:0]};
  assign ctrl      = row[5];
  assign line      = row[4:0];
  assign dat_idx   = IDX_W'({ctrl, line, cnt_q[4:0]});
  assign byte_last = cnt_q[4:0] == (wide_i ? LAST_BYTE_WIDE : LAST_BYTE_NARROW);
  assign clr_last  = wide_i ? LastWide : LastNarrow;
  assign dat_byte  = (dat_idx < StoreLim) ? mem_rdata_i : 8'h00;

  always_comb begin
    case (cnt_q[1:0])
      SLOT_EXT_BASE: cmd_val = CMD_EXT_BASE;
      SLOT_EXT_GFX:  cmd_val = CMD_EXT_GFX;
      SLOT_ROW:      cmd_val = CMD_ADDR | {3'b000, line};
      SLOT_COL:      cmd_val = CMD_ADDR;
      default:       cmd_val = CMD_ADDR;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_WIPE: begin
        if (cnt_q == LastStore) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_SET_PIXEL: state_d = pix_ok ? ST_PX_RD : ST_IDLE;
            OP_CLEAR:     state_d = ST_CLR;
            OP_INVERT:    state_d = ST_INV_RD;
            OP_INIT:      state_d = ST_ON;
            OP_REFRESH:   state_d = ST_CMD;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_PX_RD:  state_d = ST_PX_WR;
      ST_PX_WR:  state_d = ST_IDLE;
      ST_CLR: begin
        if (cnt_q == clr_last) state_d = ST_IDLE;
      end
      ST_INV_RD: state_d = ST_INV_WR;
      ST_INV_WR: begin
        state_d = (cnt_q == clr_last) ? ST_IDLE : ST_INV_RD;
      end
      ST_ON: begin
        if (out_free && (cnt_q[0] || !wide_i)) state_d = ST_IDLE;
      end
      ST_CMD: begin
        if (out_free && cnt_q[1:0] == SLOT_COL) state_d = ST_DRD;
      end
      ST_DRD:    state_d = ST_DOUT;
      ST_DOUT: begin
        if (out_free) state_d = byte_last ? ST_IDLE : ST_DRD;
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_d       = cnt_q;
    rr_d        = rr_q;
    pix_addr_d  = pix_addr_q;
    pix_mask_d  = pix_mask_q;
    pix_on_d    = pix_on_q;
    mem_re_o    = 1'b0;
    mem_we_o    = 1'b0;
    mem_addr_o  = cnt_q[AddrW-1:0];
    mem_wdata_o = 8'h00;
    emit        = 1'b0;
    emit_word   = make_word(1'b0, cmd_val, ctrl, 1'b0, 1'b0);
    cmd_i.ready = state_q == ST_IDLE;

    case (state_q)
      ST_WIPE, ST_CLR: begin
        mem_we_o = 1'b1;
        cnt_d    = cnt_q + 1'b1;
      end
      ST_IDLE: begin
        pix_addr_d = pix_idx[AddrW-1:0];
        pix_mask_d = 8'h80 >> cmd_i.pixel_x[2:0];
        pix_on_d   = cmd_i.pixel_on;
        if (accept) begin
          cnt_d = (op == OP_REFRESH && line != 5'd0) ? CntW'(SLOT_ROW) : '0;
        end
      end
      ST_PX_RD: begin
        mem_re_o   = 1'b1;
        mem_addr_o = pix_addr_q;
      end
      ST_PX_WR: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = pix_addr_q;
        mem_wdata_o = pix_on_q ? (mem_rdata_i | pix_mask_q) : (mem_rdata_i & ~pix_mask_q);
      end
      ST_INV_RD: begin
        mem_re_o = 1'b1;
      end
      ST_INV_WR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = ~mem_rdata_i;
        cnt_d       = cnt_q + 1'b1;
      end
      ST_ON: begin
        emit      = out_free;
        emit_word = make_word(1'b0, CMD_DISP_ON, cnt_q[0], 1'b1, cnt_q[0] || !wide_i);
        if (out_free) cnt_d = cnt_q + 1'b1;
      end
      ST_CMD: begin
        emit = out_free;
        if (out_free) begin
          cnt_d = (cnt_q[1:0] == SLOT_COL) ? '0 : cnt_q + 1'b1;
        end
      end
      ST_DRD: begin
        mem_re_o   = 1'b1;
        mem_addr_o = dat_idx[AddrW-1:0];
      end
      ST_DOUT: begin
        emit      = out_free;
        emit_word = make_word(1'b1, dat_byte, ctrl, byte_last && line == LAST_LINE,
                              byte_last);
        if (out_free) begin
          cnt_d = cnt_q + 1'b1;
          if (byte_last) rr_d = wide_i ? row + 6'd1 : {1'b0, line + 5'd1};
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // Output register: a finished word waits here while the sequencer moves on.
  always_comb begin
    out_valid_d = out_valid_q;
    word_d      = word_q;
    if (emit) begin
      out_valid_d = 1'b1;
      word_d      = emit_word;
    end else if (word_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_WIPE;
      cnt_q       <= '0;
      rr_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rr_q        <= rr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pix_addr_q <= pix_addr_d;
    pix_mask_q <= pix_mask_d;
    pix_on_q   <= pix_on_d;
    word_q     <= word_d;
  end

  assign word_o.valid             = out_valid_q;
  assign word_o.is_data           = word_q.is_data;
  assign word_o.word_value        = word_q.word_value;
  assign word_o.serial_frame      = word_q.serial_frame;
  assign word_o.controller        = word_q.controller;
  assign word_o.end_of_controller = word_q.end_of_controller;
  assign word_o.last              = word_q.last;

endmodule

`default_nettype wire

FILE: rtl/core/lcd_framebuffer_serial_refresh.sv
// Set pixel: byte read, then write back; clear: zeroes each active byte in turn;
// invert: reads each active byte, then writes it back inverted; init: one word per
// cycle while the output drains. Refresh row: 2 to 4 command words at one per cycle
// while the output drains, then for each data byte a store read, then the output register.
// After reset the store is swept to zero, one byte per cycle over the whole store,
// before the first transaction is taken; wide_panel and the row counter reset to zero.
`default_nettype none

`include "lcd_framebuffer_serial_refresh_macros.svh"

module lcd_framebuffer_serial_refresh
  import lcdfb_pkg::*;
#(
  parameter int unsigned STORE_BYTES = STORE_BYTES_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  lcdfb_cfg_if.sink     cfg_i,
  lcdfb_cmd_if.sink     cmd_i,
  lcdfb_word_if.source  word_o
);

  localparam int unsigned AddrW = $clog2(STORE_BYTES);

  logic             wide_q;
  logic             mem_re;
  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata;
  logic [7:0]       mem_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wide_q <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      wide_q <= cfg_i.wide_panel;
    end
  end

  lcdfb_ctrl #(
    .StoreBytes (STORE_BYTES),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wide_i      (wide_q),
    .cmd_i       (cmd_i),
    .word_o      (word_o),
    .mem_re_o    (mem_re),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  lcdfb_store #(
    .Depth (STORE_BYTES),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (mem_re),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // The sync byte must agree with the word type.
  `LCDFB_ASSERT_IMP(a_sync_matches_type, word_o.valid, word_o.serial_frame[23:16] == (word_o.is_data ? SYNC_DATA : SYNC_CMD))
  // A data word that closes a controller is always the final word of its row.
  `LCDFB_ASSERT_IMP(a_data_eoc_is_last, word_o.valid && word_o.is_data && word_o.end_of_controller, word_o.last)
  // The serial frame carries the word value split into nibbles.
  `LCDFB_ASSERT_IMP(a_frame_nibbles, word_o.valid, word_o.serial_frame[15:12] == word_o.word_value[7:4] && word_o.serial_frame[7:4] == word_o.word_value[3:0])

endmodule

`default_nettype wire

FILE: tb/sv/lcd_framebuffer_serial_refresh_test.sv
`default_nettype none

module lcd_framebuffer_serial_refresh_test;
  import lcdfb_pkg::*;

  localparam int STORE_SIZE    = STORE_BYTES_DEF;
  localparam int SETTLE_CYCLES = 2 * STORE_SIZE + 256;
  localparam int HOLD_CYCLES   = 600;
  localparam int PHASE_ITEMS   = 20;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int PRINT_LIMIT   = 60;
  localparam longint TIMEOUT_UNITS = 64'd10_000_000;

  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam logic [7:0] SYNC_CMD_BYTE  = 8'hF8;
  localparam logic [7:0] SYNC_DATA_BYTE = 8'hFA;
  localparam logic [7:0] EXT_BASE_CMD   = 8'h24;
  localparam logic [7:0] EXT_GFX_CMD    = 8'h26;
  localparam logic [7:0] ADDR_CMD       = 8'h80;
  localparam logic [7:0] DISPLAY_ON     = 8'h0C;

  localparam word_t NO_WORD            = '0;
  localparam word_t DISP_ON_UPPER      = {1'b0, 8'h0C, 24'hF800C0, 1'b0, 1'b1, 1'b0};
  localparam word_t DISP_ON_UPPER_LAST = {1'b0, 8'h0C, 24'hF800C0, 1'b0, 1'b1, 1'b1};
  localparam word_t DISP_ON_LOWER_LAST = {1'b0, 8'h0C, 24'hF800C0, 1'b1, 1'b1, 1'b1};

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] x;
    logic [6:0] y;
    logic       on;
  } cmd_t;

  typedef struct packed {
    logic       wide;
    logic [2:0] op;
    logic [7:0] x;
    logic [6:0] y;
    logic       on;
    logic       typed;
    logic [1:0] n_words;
    word_t      w0;
    word_t      w1;
  } row_t;

  // Rows marked typed carry their full word list; the others go through the predictor.
  row_t stim_table [0:24] = '{
    {1'b0, OP_INIT,      8'd0,   7'd0,   1'b0, 1'b1, 2'd1, DISP_ON_UPPER_LAST, NO_WORD},
    {1'b0, OP_SPARE_5,   8'hFF,  7'h7F,  1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_SPARE_6,   8'h00,  7'h00,  1'b0, 1'b1, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_SPARE_7,   8'hAA,  7'h55,  1'b1, 1'b1, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_SET_PIXEL, 8'd0,   7'd0,   1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_SET_PIXEL, 8'd127, 7'd63,  1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_SET_PIXEL, 8'd15,  7'd31,  1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_SET_PIXEL, 8'd16,  7'd32,  1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_SET_PIXEL, 8'd128, 7'd0,   1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_SET_PIXEL, 8'd0,   7'd64,  1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_SET_PIXEL, 8'd255, 7'd127, 1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_SET_PIXEL, 8'd127, 7'd63,  1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_REFRESH,   8'd0,   7'd0,   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_REFRESH,   8'hFF,  7'h7F,  1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_INVERT,    8'd0,   7'd0,   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_REFRESH,   8'd0,   7'd0,   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_CLEAR,     8'd0,   7'd0,   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b0, OP_REFRESH,   8'd0,   7'd0,   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b1, OP_INIT,      8'd0,   7'd0,   1'b0, 1'b1, 2'd2, DISP_ON_UPPER, DISP_ON_LOWER_LAST},
    {1'b1, OP_SET_PIXEL, 8'd191, 7'd63,  1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b1, OP_SET_PIXEL, 8'd192, 7'd5,   1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b1, OP_SET_PIXEL, 8'd128, 7'd40,  1'b1, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b1, OP_REFRESH,   8'd0,   7'd0,   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b1, OP_INVERT,    8'd0,   7'd0,   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD},
    {1'b1, OP_REFRESH,   8'd0,   7'd0,   1'b0, 1'b0, 2'd0, NO_WORD, NO_WORD}
  };

  logic clk_i;
  logic rst_ni;

  lcdfb_cfg_if  cfg_bus ();
  lcdfb_cmd_if  cmd_bus ();
  lcdfb_word_if word_bus ();

  lcd_framebuffer_serial_refresh #(
    .STORE_BYTES(STORE_SIZE)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_bus),
    .cmd_i (cmd_bus),
    .word_o(word_bus)
  );

  // Shadow copy of the panel state.
  logic [7:0] shadow_store [0:STORE_SIZE-1];
  logic [5:0] shadow_row;
  logic       shadow_wide;

  word_t item_words [$];
  word_t typed_words [$];
  word_t words_due [$];

  int mismatch_count = 0;
  bit send_gaps = 1'b0;
  bit ready_gaps = 1'b0;
  bit hold_req = 1'b0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    end
  endtask

  function automatic void push_word(logic is_data, logic [7:0] val, logic ctrl, logic eoc);
    word_t w;
    w.is_data           = is_data;
    w.word_value        = val;
    w.serial_frame      = {(is_data ? SYNC_DATA_BYTE : SYNC_CMD_BYTE), val[7:4], 4'h0,
                           val[3:0], 4'h0};
    w.controller        = ctrl;
    w.end_of_controller = eoc;
    w.last              = 1'b0;
    item_words.push_back(w);
  endfunction

  function automatic void predict_lcd_words(cmd_t c);
    int unsigned idx;
    int unsigned span;
    int unsigned base;
    int unsigned nbytes;
    int unsigned i;
    logic [15:0] mask;
    logic [5:0]  row;
    logic [4:0]  line;
    logic [7:0]  data;
    word_t       w;
    item_words.delete();
    span = shadow_wide ? 2048 : 1024;
    if (span > STORE_SIZE) begin
      span = STORE_SIZE;
    end
    case (c.op)
      OP_SET_PIXEL: begin
        if (int'(c.x) < (shadow_wide ? 192 : 128) && int'(c.y) < 64) begin
          idx = (int'(c.x) / 16) * 2 + 32 * (int'(c.y) % 32);
          if (c.y >= 32) begin
            idx += shadow_wide ? 1024 : 16;
          end
          mask = 16'h8000 >> c.x[3:0];
          if (idx < STORE_SIZE) begin
            shadow_store[idx] = c.on ? (shadow_store[idx] | mask[15:8])
                                     : (shadow_store[idx] & ~mask[15:8]);
          end
          if (idx + 1 < STORE_SIZE) begin
            shadow_store[idx+1] = c.on ? (shadow_store[idx+1] | mask[7:0])
                                       : (shadow_store[idx+1] & ~mask[7:0]);
          end
        end
      end
      OP_CLEAR: begin
        for (i = 0; i < span; i++) shadow_store[i] = 8'h00;
      end
      OP_INVERT: begin
        for (i = 0; i < span; i++) shadow_store[i] = ~shadow_store[i];
      end
      OP_INIT: begin
        push_word(1'b0, DISPLAY_ON, 1'b0, 1'b1);
        if (shadow_wide) begin
          push_word(1'b0, DISPLAY_ON, 1'b1, 1'b1);
        end
      end
      OP_REFRESH: begin
        // The narrow panel ignores the top bit of the row counter.
        row    = shadow_wide ? shadow_row : {1'b0, shadow_row[4:0]};
        line   = row[4:0];
        nbytes = shadow_wide ? 24 : 32;
        base   = int'(row[5]) * 1024 + int'(line) * 32;
        if (line == 5'd0) begin
          push_word(1'b0, EXT_BASE_CMD, row[5], 1'b0);
          push_word(1'b0, EXT_GFX_CMD, row[5], 1'b0);
        end
        push_word(1'b0, ADDR_CMD | {3'b000, line}, row[5], 1'b0);
        push_word(1'b0, ADDR_CMD, row[5], 1'b0);
        for (i = 0; i < nbytes; i++) begin
          data = (base + i < STORE_SIZE) ? shadow_store[base+i] : 8'h00;
          push_word(1'b1, data, row[5], (line == 5'd31) && (i == nbytes - 1));
        end
        shadow_row = shadow_wide ? row + 6'd1 : {1'b0, row[4:0] + 5'd1};
      end
      default: begin
      end
    endcase
    if (item_words.size() > 0) begin
      w      = item_words.pop_back();
      w.last = 1'b1;
      item_words.push_back(w);
    end
  endfunction

  function automatic cmd_t random_cmd(logic [2:0] op);
    cmd_t c;
    c.op = op;
    c.x  = 8'($urandom_range(0, 255));
    c.y  = 7'($urandom_range(0, 127));
    c.on = 1'($urandom_range(0, 1));
    if (op == OP_SET_PIXEL) begin
      if ($urandom_range(0, 9) != 0) c.x = 8'($urandom_range(0, shadow_wide ? 191 : 127));
      if ($urandom_range(0, 9) != 0) c.y = 7'($urandom_range(0, 63));
      if ($urandom_range(0, 3) != 0) c.on = 1'b1;
    end
    return c;
  endfunction

  task automatic send_cmd(input cmd_t c, input bit typed);
    int gap;
    cmd_bus.valid     <= 1'b1;
    cmd_bus.operation <= c.op;
    cmd_bus.pixel_x   <= c.x;
    cmd_bus.pixel_y   <= c.y;
    cmd_bus.pixel_on  <= c.on;
    do @(posedge clk_i); while (cmd_bus.ready !== 1'b1);
    predict_lcd_words(c);
    if (typed) begin
      foreach (typed_words[k]) words_due.push_back(typed_words[k]);
    end else begin
      foreach (item_words[k]) words_due.push_back(item_words[k]);
    end
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Clear and invert leave nothing to wait for, so the settle covers a full invert.
  task automatic wait_quiet();
    cmd_bus.valid <= 1'b0;
    while (words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_panel(input logic wide);
    wait_quiet();
    cfg_bus.valid      <= 1'b1;
    cfg_bus.wide_panel <= wide;
    do @(posedge clk_i); while (cfg_bus.ready !== 1'b1);
    shadow_wide = wide;
    cfg_bus.valid <= 1'b0;
  endtask

  // Output side: back-pressure and the long hold-off.
  initial begin
    int gap;
    word_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        word_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
        word_bus.ready <= 1'b1;
      end else if (ready_gaps && $urandom_range(0, 3) == 0) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        word_bus.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
        word_bus.ready <= 1'b1;
      end else begin
        word_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    word_t got;
    word_t want;
    if (rst_ni && word_bus.valid && word_bus.ready) begin
      got.is_data           = word_bus.is_data;
      got.word_value        = word_bus.word_value;
      got.serial_frame      = word_bus.serial_frame;
      got.controller        = word_bus.controller;
      got.end_of_controller = word_bus.end_of_controller;
      got.last              = word_bus.last;
      if (words_due.size() == 0) begin
        report_mismatch($sformatf("word %h with nothing outstanding", got));
      end else begin
        want = words_due.pop_front();
        check_field("is_data", got.is_data, want.is_data);
        check_field("word_value", got.word_value, want.word_value);
        check_field("serial_frame", got.serial_frame, want.serial_frame);
        check_field("controller", got.controller, want.controller);
        check_field("end_of_controller", got.end_of_controller, want.end_of_controller);
        check_field("last", got.last, want.last);
      end
    end
  end

  initial begin
    #(TIMEOUT_UNITS);
    $display("status: fail");
    $finish;
  end

  initial begin
    int   i;
    int   ph;
    int   done;
    int   len;
    int   pick;
    int   wait_cycles;
    row_t r;
    cmd_t c;

    rst_ni             <= 1'b0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.wide_panel <= 1'b0;
    cmd_bus.valid      <= 1'b0;
    cmd_bus.operation  <= OP_SET_PIXEL;
    cmd_bus.pixel_x    <= 8'd0;
    cmd_bus.pixel_y    <= 7'd0;
    cmd_bus.pixel_on   <= 1'b0;
    for (i = 0; i < STORE_SIZE; i++) shadow_store[i] = 8'h00;
    shadow_row  = 6'd0;
    shadow_wide = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_gaps  = 1'b1;
    ready_gaps = 1'b1;
    set_panel(1'b0);

    for (i = 0; i < 25; i++) begin
      r = stim_table[i];
      if (r.wide != shadow_wide) begin
        set_panel(r.wide);
      end
      typed_words.delete();
      if (r.n_words >= 1) typed_words.push_back(r.w0);
      if (r.n_words >= 2) typed_words.push_back(r.w1);
      c.op = r.op;
      c.x  = r.x;
      c.y  = r.y;
      c.on = r.on;
      send_cmd(c, r.typed);
    end

    // Alternate the panel mode; the row counter carries across mode changes.
    for (ph = 0; ph < 4; ph++) begin
      set_panel(ph[0]);
      send_gaps  = (ph != 0);
      ready_gaps = (ph != 0);
      if (ph == 2) begin
        // The sink stalls while rows keep coming, so the block has to back up.
        hold_req = 1'b1;
        repeat (8) send_cmd(random_cmd(OP_REFRESH), 1'b0);
      end
      done = 0;
      while (done < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          len = $urandom_range(1, 6);
          repeat (len) send_cmd(random_cmd(OP_SET_PIXEL), 1'b0);
          done += len;
        end else if (pick < 80) begin
          len = shadow_wide ? $urandom_range(4, 24) : $urandom_range(1, 12);
          repeat (len) send_cmd(random_cmd(OP_REFRESH), 1'b0);
          done += len;
        end else if (pick < 86) begin
          send_cmd(random_cmd(OP_CLEAR), 1'b0);
          done++;
        end else if (pick < 92) begin
          send_cmd(random_cmd(OP_INVERT), 1'b0);
          done++;
        end else if (pick < 96) begin
          send_cmd(random_cmd(OP_INIT), 1'b0);
          done++;
        end else begin
          send_cmd(random_cmd(3'($urandom_range(OP_SPARE_5, OP_SPARE_7))), 1'b0);
        end
      end
      // Finish the frame so the lower controller sees its last line.
      if (ph == 1) begin
        while (shadow_row != 6'd0) send_cmd(random_cmd(OP_REFRESH), 1'b0);
      end
    end

    cmd_bus.valid <= 1'b0;
    wait_cycles = 0;
    while (words_due.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (words_due.size() != 0) begin
      report_mismatch($sformatf("%0d words never arrived", words_due.size()));
    end
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
